/* design/pptd_pkg.sv */
// ----------------------------------------------------------------------------
// pptd_pkg: shared types and constants of the pump pulse timer
// Field widths, request/result structs, configuration register indexes and
// the configuration bundle passed from the register file to the datapath.
// ----------------------------------------------------------------------------
package pptd_pkg;

  // Width of the usage, limit and day timers.
  localparam int TIME_WIDTH = 27;
  localparam int PULSE_WIDTH = 24;
  localparam int CFG_DATA_WIDTH = (TIME_WIDTH > PULSE_WIDTH) ? TIME_WIDTH : PULSE_WIDTH;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int SUM_WIDTH = CFG_DATA_WIDTH + 1;

  localparam logic [TIME_WIDTH-1:0] DAILY_LIMIT_RESET = TIME_WIDTH'(300000);
  localparam logic [PULSE_WIDTH-1:0] PULSE_CREDIT_RESET = PULSE_WIDTH'(10000);
  localparam logic [TIME_WIDTH-1:0] DAY_LENGTH_RESET = TIME_WIDTH'(86400000);
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_DAILY_LIMIT  = 3'd0,
    CFG_PULSE_CREDIT = 3'd1,
    CFG_DAY_LENGTH   = 3'd2,
    CFG_RELAY_POL    = 3'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_SET  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                   command;
    logic                   turn_on;
    logic [PULSE_WIDTH-1:0] pulse_ms;
  } req_t;

  typedef struct packed {
    logic                  pump_running;
    logic                  relay_level;
    logic                  auto_off_armed;
    logic                  limit_refused;
    logic                  pulse_expired;
    logic                  day_rolled;
    logic [TIME_WIDTH-1:0] usage_today_ms;
  } rsp_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]  daily_limit_ms;
    logic [PULSE_WIDTH-1:0] pulse_credit_ms;
    logic [TIME_WIDTH-1:0]  day_length_ms;
    logic                   relay_active_high;
  } cfg_t;

endpackage

/* design/pptd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pptd_cfg_regs: configuration register file
// Four write-only registers loaded from a plain write port. Writes to an
// unused index are dropped.
// ----------------------------------------------------------------------------
module pptd_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pptd_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx_i,
  input  logic [pptd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data_i,
  output pptd_pkg::cfg_t                        cfg_o
);
  import pptd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DAILY_LIMIT:  cfg_d.daily_limit_ms    = cfg_data_i[TIME_WIDTH-1:0];
        CFG_PULSE_CREDIT: cfg_d.pulse_credit_ms   = cfg_data_i[PULSE_WIDTH-1:0];
        CFG_DAY_LENGTH:   cfg_d.day_length_ms     = cfg_data_i[TIME_WIDTH-1:0];
        CFG_RELAY_POL:    cfg_d.relay_active_high = cfg_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.daily_limit_ms    <= DAILY_LIMIT_RESET;
      cfg_q.pulse_credit_ms   <= PULSE_CREDIT_RESET;
      cfg_q.day_length_ms     <= DAY_LENGTH_RESET;
      cfg_q.relay_active_high <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/pptd_core.sv */
// ----------------------------------------------------------------------------
// pptd_core: pump state and timers
// Holds the pump, pulse and day state and applies one request per enabled
// cycle, producing that request's result combinationally.
// ----------------------------------------------------------------------------
module pptd_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  pptd_pkg::req_t req_i,
  input  pptd_pkg::cfg_t cfg_i,
  output pptd_pkg::rsp_t rsp_o
);
  import pptd_pkg::*;

  logic                   pump_q, pump_d;
  logic                   armed_q, armed_d;
  logic [PULSE_WIDTH-1:0] pulse_rem_q, pulse_rem_d;
  logic [TIME_WIDTH-1:0]  usage_q, usage_d;
  logic [TIME_WIDTH-1:0]  day_rem_q, day_rem_d;
  logic                   refused, expired, rolled;
  logic [SUM_WIDTH-1:0]   credit_sum;

  assign credit_sum = SUM_WIDTH'(usage_q) + SUM_WIDTH'(cfg_i.pulse_credit_ms);

  always_comb begin
    pump_d      = pump_q;
    armed_d     = armed_q;
    pulse_rem_d = pulse_rem_q;
    usage_d     = usage_q;
    day_rem_d   = day_rem_q;
    refused     = 1'b0;
    expired     = 1'b0;
    rolled      = 1'b0;
    if (req_i.command == CMD_SET) begin
      if (req_i.turn_on && (usage_q >= cfg_i.daily_limit_ms)) begin
        refused = 1'b1;
        pump_d  = 1'b0;
        armed_d = 1'b0;
      end else begin
        pump_d  = req_i.turn_on;
        armed_d = req_i.turn_on && (req_i.pulse_ms != '0);
        if (req_i.turn_on && (req_i.pulse_ms != '0)) begin
          pulse_rem_d = req_i.pulse_ms;
        end
      end
    end else begin
      if (armed_q) begin
        if (pulse_rem_q <= PULSE_WIDTH'(1)) begin
          pulse_rem_d = '0;
          armed_d     = 1'b0;
          pump_d      = 1'b0;
          expired     = 1'b1;
          usage_d     = (credit_sum > SUM_WIDTH'(TIME_MAX)) ? TIME_MAX
                                                            : credit_sum[TIME_WIDTH-1:0];
        end else begin
          pulse_rem_d = pulse_rem_q - PULSE_WIDTH'(1);
        end
      end
      // The day clearing runs after the pulse credit, so it wins on a shared tick.
      if (day_rem_q <= TIME_WIDTH'(1)) begin
        day_rem_d = cfg_i.day_length_ms;
        usage_d   = '0;
        rolled    = 1'b1;
      end else begin
        day_rem_d = day_rem_q - TIME_WIDTH'(1);
      end
    end
  end

  always_comb begin
    rsp_o.pump_running   = pump_d;
    rsp_o.relay_level    = pump_d ^ ~cfg_i.relay_active_high;
    rsp_o.auto_off_armed = armed_d;
    rsp_o.limit_refused  = refused;
    rsp_o.pulse_expired  = expired;
    rsp_o.day_rolled     = rolled;
    rsp_o.usage_today_ms = usage_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_q      <= 1'b0;
      armed_q     <= 1'b0;
      pulse_rem_q <= '0;
      usage_q     <= '0;
      day_rem_q   <= DAY_LENGTH_RESET;
    end else if (step_i) begin
      pump_q      <= pump_d;
      armed_q     <= armed_d;
      pulse_rem_q <= pulse_rem_d;
      usage_q     <= usage_d;
      day_rem_q   <= day_rem_d;
    end
  end

  // An armed countdown always belongs to a running pump.
  a_armed_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> pump_q)
    else $error("auto-off armed while pump is off");

  a_armed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> (pulse_rem_q != '0))
    else $error("armed pulse countdown holds zero");

  a_roll_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && rolled) |=> (usage_q == '0) && (day_rem_q == $past(cfg_i.day_length_ms)))
    else $error("day rollover did not clear usage and reload the day timer");

endmodule

/* design/pump_pulse_timer_with_daily_limit.sv */
// ----------------------------------------------------------------------------
// pump_pulse_timer_with_daily_limit: pump relay controller top level
// Set requests and one-millisecond ticks drive a pump with an auto-off pulse
// and a daily usage limit; one result comes back for every request.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while results are taken. An
// accepted request is captured in an input register. When the output register
// is free, the pump and timer state are updated in one pass and the result is
// loaded into that output register, where it is held until taken. Back-to-back
// requests stream at full rate as long as results are taken, since pptd_core
// updates its state in one pass per request. While a result waits, one
// more request can sit in the input register before the input stalls. After
// reset the day countdown starts from the reset day length; configuration
// writes take effect on the next request.
module pump_pulse_timer_with_daily_limit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pptd_pkg::req_t                      in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pptd_pkg::rsp_t                      out_rsp_o,
  input  logic                                cfg_we_i,
  input  logic [pptd_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [pptd_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i
);
  import pptd_pkg::*;

  cfg_t cfg;
  req_t req_q;
  rsp_t rsp_q, rsp;
  logic req_valid_q;
  logic rsp_valid_q;
  logic out_free;
  logic step;

  assign out_free   = !rsp_valid_q || out_ready_i;
  assign step       = req_valid_q && out_free;
  assign in_ready_o = !req_valid_q || step;

  pptd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pptd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (req_q),
    .cfg_i  (cfg),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        req_valid_q <= 1'b1;
      end else if (step) begin
        req_valid_q <= 1'b0;
      end
      if (step) begin
        rsp_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (step) begin
      rsp_q <= rsp;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_rsp_o   = rsp_q;

  // A held request is never dropped while the result register is blocked.
  a_req_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && !step) |=> req_valid_q)
    else $error("pending request lost while output stalled");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !out_ready_i) |-> !step)
    else $error("result overwritten before it was taken");

  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> rsp_valid_q)
    else $error("processed request produced no result");

endmodule
